[rtl/core/fgti_pkg.sv]
// Shared widths, constants and transfer types for the fuzzy green-time inference block.
`default_nettype none

package fgti_pkg;

  localparam int INPUT_FRAC_BITS = 4;
  localparam int GRADE_FRAC_BITS = 8;
  localparam int OUT_FRAC_BITS   = 8;

  localparam int IN_W    = 12;
  localparam int DUR_W   = 6;
  localparam int GT_W    = 14;
  localparam int GRADE_W = GRADE_FRAC_BITS + 1;
  localparam int DEN_W   = GRADE_W + 2;
  localparam int NUM_W   = DEN_W + DUR_W;

  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SHORT  = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_MIDDLE = CFG_IDX_W'(1);
  localparam logic [CFG_IDX_W-1:0] CFG_LONG   = CFG_IDX_W'(2);

  localparam logic [DUR_W-1:0] SHORT_RST  = DUR_W'(10);
  localparam logic [DUR_W-1:0] MIDDLE_RST = DUR_W'(30);
  localparam logic [DUR_W-1:0] LONG_RST   = DUR_W'(50);

  localparam int DIV_STEPS  = 2;
  localparam int DIV_STAGES = GT_W / DIV_STEPS;

  typedef struct packed {
    logic [IN_W-1:0] arriving_count;
    logic [IN_W-1:0] queue_count;
    logic [IN_W-1:0] fog_level;
  } in_item_t;

  typedef struct packed {
    logic [GT_W-1:0] green_time;
    logic            no_rule_fired;
  } out_item_t;

  typedef struct packed {
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
    logic             none;
  } div_in_t;

endpackage

`default_nettype wire

[rtl/core/fgti_div.sv]
// Pipelined restoring divider: green time = (num << 8) / den, two quotient bits per stage.
`default_nettype none

module fgti_div (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               in_valid,
  input  wire fgti_pkg::div_in_t  in_op,
  output logic                    out_valid,
  output fgti_pkg::out_item_t     out_item
);
  import fgti_pkg::*;

  localparam int LOW_W = NUM_W - DEN_W;

  logic [DIV_STAGES-1:0] vld_r;
  logic [DEN_W-1:0]      rem_r  [DIV_STAGES];
  logic [DEN_W-1:0]      den_r  [DIV_STAGES];
  logic [GT_W-1:0]       bits_r [DIV_STAGES];
  logic [GT_W-1:0]       quo_r  [DIV_STAGES];
  logic                  none_r [DIV_STAGES];

  for (genvar s = 0; s < DIV_STAGES; s++) begin : g_stage
    logic             vld_in;
    logic [DEN_W-1:0] rem_in;
    logic [DEN_W-1:0] den_in;
    logic [GT_W-1:0]  bits_in;
    logic [GT_W-1:0]  quo_in;
    logic             none_in;
    logic [DEN_W-1:0] rem_nxt;
    logic [GT_W-1:0]  bits_nxt;
    logic [GT_W-1:0]  quo_nxt;

    if (s == 0) begin : g_first
      // quotient < 2^14, so the top bits of the dividend are already below den
      assign vld_in  = in_valid;
      assign rem_in  = in_op.num[NUM_W-1 -: DEN_W];
      assign den_in  = in_op.den;
      assign bits_in = {in_op.num[LOW_W-1:0], {OUT_FRAC_BITS{1'b0}}};
      assign quo_in  = '0;
      assign none_in = in_op.none;
    end else begin : g_next
      assign vld_in  = vld_r[s-1];
      assign rem_in  = rem_r[s-1];
      assign den_in  = den_r[s-1];
      assign bits_in = bits_r[s-1];
      assign quo_in  = quo_r[s-1];
      assign none_in = none_r[s-1];
    end

    always_comb begin
      logic [DEN_W:0] r2;
      logic           ge;
      rem_nxt  = rem_in;
      bits_nxt = bits_in;
      quo_nxt  = quo_in;
      for (int k = 0; k < DIV_STEPS; k++) begin
        r2       = {rem_nxt, bits_nxt[GT_W-1]};
        bits_nxt = {bits_nxt[GT_W-2:0], 1'b0};
        ge       = (r2 >= {1'b0, den_in});
        if (ge) begin
          r2 = r2 - {1'b0, den_in};
        end
        rem_nxt = r2[DEN_W-1:0];
        quo_nxt = {quo_nxt[GT_W-2:0], ge};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[s] <= 1'b0;
      end else begin
        vld_r[s] <= vld_in;
      end
      rem_r[s]  <= rem_nxt;
      den_r[s]  <= den_in;
      bits_r[s] <= bits_nxt;
      quo_r[s]  <= quo_nxt;
      none_r[s] <= none_in;
    end
  end

  assign out_valid              = vld_r[DIV_STAGES-1];
  assign out_item.green_time    = none_r[DIV_STAGES-1] ? '0 : quo_r[DIV_STAGES-1];
  assign out_item.no_rule_fired = none_r[DIV_STAGES-1];

endmodule

`default_nettype wire

[rtl/core/fuzzy_green_time_inference_top.sv]
// Top level: fuzzy grading, rule strengths, weighted sums and divider pipeline.
//
//   channel   ports                                  transfer when
//   input     start, busy, in_data                   start && !busy
//   result    out_valid, out_data                    out_valid (one cycle)
//   config    cfg_we, cfg_idx, cfg_wdata             cfg_we
//
// One item may enter every cycle; busy stays low.
// Pipeline: grades, rule mins, weighted sums, then 7 divider
// stages resolving 2 quotient bits each.
// Synchronous active-low reset clears the valid bits and restores durations 10/30/50.
// The receiver cannot stall; results stream out in input order.
`default_nettype none

module fuzzy_green_time_inference_top (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                start,
  output logic                                     busy,
  input  wire fgti_pkg::in_item_t                  in_data,
  output logic                                     out_valid,
  output fgti_pkg::out_item_t                      out_data,
  input  wire logic                                cfg_we,
  input  wire logic [fgti_pkg::CFG_IDX_W-1:0]      cfg_idx,
  input  wire logic [fgti_pkg::DUR_W-1:0]          cfg_wdata
);
  import fgti_pkg::*;

  localparam logic [IN_W-1:0] P10 = IN_W'(10 << INPUT_FRAC_BITS);
  localparam logic [IN_W-1:0] P20 = IN_W'(20 << INPUT_FRAC_BITS);
  localparam logic [IN_W-1:0] P30 = IN_W'(30 << INPUT_FRAC_BITS);
  localparam logic [IN_W-1:0] P40 = IN_W'(40 << INPUT_FRAC_BITS);
  localparam logic [IN_W-1:0] P50 = IN_W'(50 << INPUT_FRAC_BITS);
  localparam logic [GRADE_W-1:0] ONE = GRADE_W'(1 << GRADE_FRAC_BITS);

  // spans are 5 * 2^k input units: scale distance, then divide by 5
  localparam int SH20       = GRADE_FRAC_BITS - INPUT_FRAC_BITS - 2;
  localparam int SH10       = GRADE_FRAC_BITS - INPUT_FRAC_BITS - 1;
  localparam int SLOPE_W    = GRADE_FRAC_BITS + 3;
  localparam int PROD_W     = 2 * SLOPE_W;
  localparam int DIV5_SHIFT = 13;
  localparam logic [PROD_W-1:0] DIV5_MUL = PROD_W'(1639);

  function automatic logic [GRADE_W-1:0] div5(input logic [SLOPE_W-1:0] m);
    logic [PROD_W-1:0] p;
    p = PROD_W'(m) * DIV5_MUL;
    return p[DIV5_SHIFT +: GRADE_W];
  endfunction

  function automatic logic [GRADE_W-1:0] grade_low(input logic [IN_W-1:0] v);
    logic [IN_W-1:0] d;
    d = P30 - v;
    if (v <= P10) return ONE;
    if (v >= P30) return '0;
    return div5(SLOPE_W'(d) << SH20);
  endfunction

  function automatic logic [GRADE_W-1:0] grade_mid(input logic [IN_W-1:0] v);
    logic [IN_W-1:0] du;
    logic [IN_W-1:0] dd;
    du = v - P10;
    dd = P50 - v;
    if (v <= P10 || v >= P50) return '0;
    if (v >= P20 && v <= P40) return ONE;
    if (v < P20) return div5(SLOPE_W'(du) << SH10);
    return div5(SLOPE_W'(dd) << SH10);
  endfunction

  function automatic logic [GRADE_W-1:0] grade_high(input logic [IN_W-1:0] v);
    logic [IN_W-1:0] d;
    d = v - P30;
    if (v >= P50) return ONE;
    if (v <= P30) return '0;
    return div5(SLOPE_W'(d) << SH20);
  endfunction

  function automatic logic [GRADE_W-1:0] min3(input logic [GRADE_W-1:0] a,
                                              input logic [GRADE_W-1:0] b,
                                              input logic [GRADE_W-1:0] c);
    logic [GRADE_W-1:0] m;
    m = (a < b) ? a : b;
    return (m < c) ? m : c;
  endfunction

  logic [DUR_W-1:0] short_r;
  logic [DUR_W-1:0] middle_r;
  logic [DUR_W-1:0] long_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      short_r  <= SHORT_RST;
      middle_r <= MIDDLE_RST;
      long_r   <= LONG_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_SHORT:  short_r  <= cfg_wdata;
        CFG_MIDDLE: middle_r <= cfg_wdata;
        CFG_LONG:   long_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  logic in_fire;
  assign in_fire = start && !busy;

  // stage 1: memberships
  logic               s1_vld_r;
  logic [GRADE_W-1:0] lo_r [3];
  logic [GRADE_W-1:0] md_r [3];
  logic [GRADE_W-1:0] hi_r [3];
  logic [IN_W-1:0]    s1_v [3];

  assign s1_v[0] = in_data.arriving_count;
  assign s1_v[1] = in_data.queue_count;
  assign s1_v[2] = in_data.fog_level;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else begin
      s1_vld_r <= in_fire;
    end
    for (int i = 0; i < 3; i++) begin
      lo_r[i] <= grade_low(s1_v[i]);
      md_r[i] <= grade_mid(s1_v[i]);
      hi_r[i] <= grade_high(s1_v[i]);
    end
  end

  // stage 2: rule strengths
  logic               s2_vld_r;
  logic [GRADE_W-1:0] wl_r;
  logic [GRADE_W-1:0] wm_r;
  logic [GRADE_W-1:0] wh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_vld_r <= 1'b0;
    end else begin
      s2_vld_r <= s1_vld_r;
    end
    wl_r <= min3(lo_r[0], lo_r[1], lo_r[2]);
    wm_r <= min3(md_r[0], md_r[1], md_r[2]);
    wh_r <= min3(hi_r[0], hi_r[1], hi_r[2]);
  end

  // stage 3: weighted sums
  logic             s3_vld_r;
  div_in_t          s3_op_r;
  div_in_t          s3_op_nxt;
  logic [NUM_W-1:0] pl;
  logic [NUM_W-1:0] pm;
  logic [NUM_W-1:0] ph;

  always_comb begin
    pl = NUM_W'(wl_r) * NUM_W'(short_r);
    pm = NUM_W'(wm_r) * NUM_W'(middle_r);
    ph = NUM_W'(wh_r) * NUM_W'(long_r);
    s3_op_nxt.num  = pl + pm + ph;
    s3_op_nxt.den  = DEN_W'(wl_r) + DEN_W'(wm_r) + DEN_W'(wh_r);
    s3_op_nxt.none = (wl_r == '0) && (wm_r == '0) && (wh_r == '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else begin
      s3_vld_r <= s2_vld_r;
    end
    s3_op_r <= s3_op_nxt;
  end

  fgti_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (s3_vld_r),
    .in_op     (s3_op_r),
    .out_valid (out_valid),
    .out_item  (out_data)
  );

endmodule

`default_nettype wire
